// ===== rtl/core/rmpa_pkg.sv =====
package rmpa_pkg;

    localparam int PRIO_W = 7;

    typedef struct packed {
        logic [15:0] task_period;
        logic [15:0] task_arrival;
        logic [7:0]  task_tag;
        logic        last_task;
    } rmpa_task_t;

    typedef struct packed {
        logic [7:0]        out_tag;
        logic [PRIO_W-1:0] out_priority;
        logic [15:0]       out_arrival;
        logic              overflow;
        logic              out_last;
    } rmpa_result_t;

    // one stored descriptor
    typedef struct packed {
        logic [15:0] period;
        logic [15:0] arrival;
        logic [7:0]  tag;
    } rmpa_entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PSCAN,
        ST_PSEL,
        ST_ASCAN,
        ST_APUT
    } rmpa_state_t;

endpackage

// ===== rtl/core/rate_monotonic_priority_assign_core.sv =====
// Rate-monotonic priority assignment. Task descriptors are loaded one beat per cycle into
// an entry memory of MAX_TASKS words; beats beyond capacity are dropped and reported on the
// overflow bit of every result of that set. The beat with last_task set closes the set, and
// the input then stalls until the last result of the set has been loaded into the output
// register. With n stored tasks the block makes n selection passes in period order, each a
// scan of the entry memory (one read a cycle from a registered read port, then a step to
// settle the selection) and a write of the priority memory, then n passes in arrival
// order, each a scan plus a load of the output register, which waits while the result
// side stalls. The shortest period gets priority n, each new distinct period one less;
// results come out ordered by arrival, ties kept in period order and then in load order.
// Only one memory access pass runs at a time, so reads and writes of the same entry never
// overlap.
module rate_monotonic_priority_assign_core #(
    parameter int MAX_TASKS = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  task_valid,
    output logic                  task_stall,
    input  rmpa_pkg::rmpa_task_t   task_data,
    output logic                  result_valid,
    input  logic                  result_stall,
    output rmpa_pkg::rmpa_result_t result_data
);
    import rmpa_pkg::*;

    localparam int IW = $clog2(MAX_TASKS);
    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam logic [CW-1:0] CAP = CW'(MAX_TASKS);

    rmpa_state_t state_reg, state_next;

    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 dropped_reg, dropped_next;
    logic [CW-1:0]        sel_cnt_reg, sel_cnt_next;
    logic [CW-1:0]        scan_addr_reg, scan_addr_next;
    logic                 rd_vld_reg, rd_vld_next;
    logic [IW-1:0]        rd_idx_reg, rd_idx_next;
    logic [MAX_TASKS-1:0] used_reg, used_next;
    logic                 best_vld_reg, best_vld_next;
    logic [IW-1:0]        best_idx_reg, best_idx_next;
    rmpa_entry_t          best_ent_reg, best_ent_next;
    logic [PRIO_W-1:0]    best_prio_reg, best_prio_next;
    logic [PRIO_W-1:0]    prio_reg, prio_next;
    logic [15:0]          prev_period_reg, prev_period_next;
    logic                 out_vld_reg, out_vld_next;
    rmpa_result_t         out_reg, out_next;

    rmpa_entry_t       entry_mem [MAX_TASKS];
    logic [PRIO_W-1:0] prio_mem [MAX_TASKS];
    rmpa_entry_t       ent_q;
    logic [PRIO_W-1:0] prio_q;

    logic        ent_we;
    rmpa_entry_t ent_wdata;
    logic        prio_we;
    logic        rd_en;

    logic          accept;
    logic          in_scan;
    logic          scan_done;
    logic          sel_last;
    logic          out_free;
    logic          per_better;
    logic          arr_better;
    logic          cand_better;
    logic [CW-1:0] sel_inc;

    assign accept    = task_valid && !task_stall;
    assign in_scan   = (state_reg == ST_PSCAN) || (state_reg == ST_ASCAN);
    assign scan_done = in_scan && (scan_addr_reg == cnt_reg) && !rd_vld_reg;
    assign sel_inc   = sel_cnt_reg + CW'(1);
    assign sel_last  = (sel_inc == cnt_reg);
    assign out_free  = !out_vld_reg || !result_stall;

    // strict compares: on a tie the lower entry, scanned first, stays selected
    assign per_better  = ent_q.period < best_ent_reg.period;
    assign arr_better  = (ent_q.arrival < best_ent_reg.arrival) ||
                         ((ent_q.arrival == best_ent_reg.arrival) &&
                          (ent_q.period < best_ent_reg.period));
    assign cand_better = (state_reg == ST_ASCAN) ? arr_better : per_better;

    assign ent_wdata = '{period:  task_data.task_period,
                         arrival: task_data.task_arrival,
                         tag:     task_data.task_tag};

    assign result_valid = out_vld_reg;
    assign result_data  = out_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && task_data.last_task)
                begin
                    state_next = ST_PSCAN;
                end
            end
            ST_PSCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_PSEL;
                end
            end
            ST_PSEL:
            begin
                state_next = sel_last ? ST_ASCAN : ST_PSCAN;
            end
            ST_ASCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_APUT;
                end
            end
            ST_APUT:
            begin
                if (out_free)
                begin
                    state_next = sel_last ? ST_IDLE : ST_ASCAN;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        task_stall       = (state_reg != ST_IDLE);
        cnt_next         = cnt_reg;
        dropped_next     = dropped_reg;
        sel_cnt_next     = sel_cnt_reg;
        scan_addr_next   = scan_addr_reg;
        rd_vld_next      = 1'b0;
        rd_idx_next      = scan_addr_reg[IW-1:0];
        used_next        = used_reg;
        best_vld_next    = best_vld_reg;
        best_idx_next    = best_idx_reg;
        best_ent_next    = best_ent_reg;
        best_prio_next   = best_prio_reg;
        prio_next        = prio_reg;
        prev_period_next = prev_period_reg;
        out_vld_next     = out_vld_reg && result_stall;
        out_next         = out_reg;
        ent_we           = 1'b0;
        prio_we          = 1'b0;
        rd_en            = 1'b0;

        // scan engine: issue one read a cycle, compare the returning word
        if (in_scan)
        begin
            if (scan_addr_reg != cnt_reg)
            begin
                rd_en          = 1'b1;
                rd_vld_next    = 1'b1;
                scan_addr_next = scan_addr_reg + CW'(1);
            end
            if (rd_vld_reg && !used_reg[rd_idx_reg] && (!best_vld_reg || cand_better))
            begin
                best_vld_next  = 1'b1;
                best_idx_next  = rd_idx_reg;
                best_ent_next  = ent_q;
                best_prio_next = prio_q;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (cnt_reg != CAP)
                    begin
                        ent_we   = 1'b1;
                        cnt_next = cnt_reg + CW'(1);
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                    if (task_data.last_task)
                    begin
                        scan_addr_next = '0;
                        best_vld_next  = 1'b0;
                        sel_cnt_next   = '0;
                    end
                end
            end
            ST_PSEL:
            begin
                if (sel_cnt_reg == '0)
                begin
                    prio_next = PRIO_W'(cnt_reg);
                end
                else if (best_ent_reg.period != prev_period_reg)
                begin
                    prio_next = prio_reg - PRIO_W'(1);
                end
                prio_we          = 1'b1;
                prev_period_next = best_ent_reg.period;
                used_next[best_idx_reg] = 1'b1;
                sel_cnt_next     = sel_inc;
                scan_addr_next   = '0;
                best_vld_next    = 1'b0;
                if (sel_last)
                begin
                    used_next    = '0;
                    sel_cnt_next = '0;
                end
            end
            ST_APUT:
            begin
                if (out_free)
                begin
                    out_vld_next = 1'b1;
                    out_next     = '{out_tag:      best_ent_reg.tag,
                                     out_priority: best_prio_reg,
                                     out_arrival:  best_ent_reg.arrival,
                                     overflow:     dropped_reg,
                                     out_last:     sel_last};
                    used_next[best_idx_reg] = 1'b1;
                    sel_cnt_next   = sel_inc;
                    scan_addr_next = '0;
                    best_vld_next  = 1'b0;
                    if (sel_last)
                    begin
                        used_next    = '0;
                        sel_cnt_next = '0;
                        cnt_next     = '0;
                        dropped_next = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            entry_mem[cnt_reg[IW-1:0]] <= ent_wdata;
        end
        if (rd_en)
        begin
            ent_q <= entry_mem[scan_addr_reg[IW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (prio_we)
        begin
            prio_mem[best_idx_reg] <= prio_next;
        end
        if (rd_en)
        begin
            prio_q <= prio_mem[scan_addr_reg[IW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            dropped_reg   <= 1'b0;
            sel_cnt_reg   <= '0;
            scan_addr_reg <= '0;
            rd_vld_reg    <= 1'b0;
            used_reg      <= '0;
            best_vld_reg  <= 1'b0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            dropped_reg   <= dropped_next;
            sel_cnt_reg   <= sel_cnt_next;
            scan_addr_reg <= scan_addr_next;
            rd_vld_reg    <= rd_vld_next;
            used_reg      <= used_next;
            best_vld_reg  <= best_vld_next;
            out_vld_reg   <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg      <= rd_idx_next;
        best_idx_reg    <= best_idx_next;
        best_ent_reg    <= best_ent_next;
        best_prio_reg   <= best_prio_next;
        prio_reg        <= prio_next;
        prev_period_reg <= prev_period_next;
        out_reg         <= out_next;
    end

endmodule

// ===== rtl/core/rmpa_chk.sv =====
module rmpa_chk (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   task_valid,
    input logic                   task_stall,
    input rmpa_pkg::rmpa_task_t   task_data,
    input logic                   result_valid,
    input logic                   result_stall,
    input rmpa_pkg::rmpa_result_t result_data
);
    import rmpa_pkg::*;

    logic task_beat;

    assign task_beat = task_valid && !task_stall;

    // a stalled result beat holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result_data))
        else $error("result beat changed while stalled");

    // loading keeps taking beats until the set is closed
    a_load_open: assert property (@(posedge clk) disable iff (!rst_n)
        task_beat && !task_data.last_task |=> !task_stall)
        else $error("input stalled in the middle of a set");

    // closing beat starts the compute, input waits
    a_set_closed: assert property (@(posedge clk) disable iff (!rst_n)
        task_beat && task_data.last_task |=> task_stall)
        else $error("input not stalled after closing beat");

    // every emitted task has a nonzero priority
    a_prio_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result_data.out_priority != '0)
        else $error("zero priority emitted");

endmodule

bind rate_monotonic_priority_assign_core rmpa_chk u_rmpa_chk (.*);

// ===== verif/rmpa_schedule_checker.sv =====
module rmpa_schedule_checker #(
    parameter int MAX_TASKS = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   task_valid,
    input  logic                   task_stall,
    input  rmpa_pkg::rmpa_task_t   task_data,
    input  logic                   result_valid,
    input  logic                   result_stall,
    input  rmpa_pkg::rmpa_result_t result_data,
    output int unsigned            mismatch_count,
    output int unsigned            results_due
);

    import rmpa_pkg::*;

    rmpa_entry_t       task_table [MAX_TASKS];
    logic [PRIO_W-1:0] rank_table [MAX_TASKS];
    int                slot_order [MAX_TASKS];
    int                loaded;
    logic              dropped;
    rmpa_result_t      schedule_q [$];

    // stable insertion sort of slot_order by period or by arrival
    function automatic void order_slots(input logic by_arrival);
        int i;
        int j;
        int held;
        logic [15:0] held_key;
        logic [15:0] prev_key;
        begin
            for (i = 1; i < loaded; i++)
            begin
                held = slot_order[i];
                held_key = by_arrival ? task_table[held].arrival : task_table[held].period;
                j = i;
                while (j > 0)
                begin
                    prev_key = by_arrival ? task_table[slot_order[j-1]].arrival
                                          : task_table[slot_order[j-1]].period;
                    if (prev_key <= held_key)
                        break;
                    slot_order[j] = slot_order[j-1];
                    j--;
                end
                slot_order[j] = held;
            end
        end
    endfunction

    function automatic void schedule_set();
        int i;
        int prio;
        rmpa_result_t r;
        begin
            for (i = 0; i < loaded; i++)
                slot_order[i] = i;
            order_slots(1'b0);
            prio = loaded + 1;
            for (i = 0; i < loaded; i++)
            begin
                if (i == 0 || task_table[slot_order[i]].period
                              != task_table[slot_order[i-1]].period)
                    prio--;
                rank_table[slot_order[i]] = prio[PRIO_W-1:0];
            end
            order_slots(1'b1);
            for (i = 0; i < loaded; i++)
            begin
                r.out_tag      = task_table[slot_order[i]].tag;
                r.out_priority = rank_table[slot_order[i]];
                r.out_arrival  = task_table[slot_order[i]].arrival;
                r.overflow     = dropped;
                r.out_last     = (i == loaded - 1);
                schedule_q.push_back(r);
            end
            loaded = 0;
            dropped = 1'b0;
        end
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        begin
            if (want !== got)
            begin
                mismatch_count++;
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded = 0;
            dropped = 1'b0;
            schedule_q.delete();
            results_due = 0;
            mismatch_count = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (schedule_q.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected result beat, expected none, actual %h",
                             $time, result_data);
                end
                else
                begin
                    check_field("out_tag", 16'(schedule_q[0].out_tag),
                                16'(result_data.out_tag));
                    check_field("out_priority", 16'(schedule_q[0].out_priority),
                                16'(result_data.out_priority));
                    check_field("out_arrival", schedule_q[0].out_arrival,
                                result_data.out_arrival);
                    check_field("overflow", 16'(schedule_q[0].overflow),
                                16'(result_data.overflow));
                    check_field("out_last", 16'(schedule_q[0].out_last),
                                16'(result_data.out_last));
                    void'(schedule_q.pop_front());
                end
            end
            if (task_valid && !task_stall)
            begin
                if (loaded < MAX_TASKS)
                begin
                    task_table[loaded].period  = task_data.task_period;
                    task_table[loaded].arrival = task_data.task_arrival;
                    task_table[loaded].tag     = task_data.task_tag;
                    loaded++;
                end
                else
                    dropped = 1'b1;
                if (task_data.last_task)
                    schedule_set();
            end
            results_due = schedule_q.size();
        end
    end

endmodule

// ===== verif/rate_monotonic_priority_assign_core_tb.sv =====
module rate_monotonic_priority_assign_core_tb;

    import rmpa_pkg::*;

    localparam int MAX_TASKS    = 8;
    localparam int BEAT_TARGET  = 480;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 300;
    localparam int CYCLE_LIMIT  = 400000;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         task_valid = 1'b0;
    logic         task_stall;
    rmpa_task_t   task_data = '0;
    logic         result_valid;
    logic         result_stall = 1'b0;
    rmpa_result_t result_data;

    int unsigned  mismatch_count;
    int unsigned  results_due;
    int           beats_sent = 0;
    int           cycle_count = 0;
    logic         hold_done = 1'b0;
    logic         idle_ok;

    // one quiet stretch with no idling on either side
    assign idle_ok = (beats_sent < 250) || (beats_sent >= 330);

    rate_monotonic_priority_assign_core #(
        .MAX_TASKS(MAX_TASKS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .task_valid(task_valid),
        .task_stall(task_stall),
        .task_data(task_data),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result_data(result_data)
    );

    rmpa_schedule_checker #(
        .MAX_TASKS(MAX_TASKS)
    ) checker_i (
        .clk(clk),
        .rst_n(rst_n),
        .task_valid(task_valid),
        .task_stall(task_stall),
        .task_data(task_data),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result_data(result_data),
        .mismatch_count(mismatch_count),
        .results_due(results_due)
    );

    initial
    begin
        forever
            #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // result side: random stalls plus one long hold-off
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!hold_done && beats_sent >= 120)
            begin
                hold_done = 1'b1;
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else
                result_stall <= idle_ok && ($urandom_range(99) < 23);
        end
    end

    task automatic send_beat(input logic [15:0] period, input logic [15:0] arrival,
                             input logic [7:0] tag, input logic last);
        begin
            while (idle_ok && $urandom_range(99) < 23)
            begin
                task_valid <= 1'b0;
                @(negedge clk);
            end
            task_valid <= 1'b1;
            task_data <= '{task_period: period, task_arrival: arrival,
                           task_tag: tag, last_task: last};
            do
                @(posedge clk);
            while (task_stall);
            beats_sent++;
            @(negedge clk);
        end
    endtask

    // small pools make period and arrival ties common
    function automatic logic [15:0] pick_tick(input logic zero_ok);
        begin
            case ($urandom_range(9))
                0: pick_tick = $urandom_range(1) ? 16'hFFFF : (zero_ok ? 16'h0000 : 16'h0001);
                1, 2, 3: pick_tick = 16'($urandom_range(4, 1));
                4, 5, 6: pick_tick = 16'($urandom);
                default: pick_tick = 16'($urandom_range(300, 1));
            endcase
        end
    endfunction

    task automatic send_random_set();
        int size;
        int i;
        begin
            size = ($urandom_range(99) < 15) ? $urandom_range(MAX_TASKS + 4, MAX_TASKS + 1)
                                             : $urandom_range(MAX_TASKS, 1);
            for (i = 0; i < size; i++)
                send_beat(pick_tick(1'b1), pick_tick(1'b1), 8'($urandom_range(255)),
                          i == size - 1);
        end
    endtask

    initial
    begin
        int i;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // single task at the top of every field
        send_beat(16'hFFFF, 16'hFFFF, 8'hFF, 1'b1);
        // zero and minimum periods, a period tie, an arrival tie
        send_beat(16'h0000, 16'd100, 8'h00, 1'b0);
        send_beat(16'h0001, 16'd100, 8'h01, 1'b0);
        send_beat(16'h0001, 16'd50, 8'h02, 1'b0);
        send_beat(16'hFFFF, 16'h0000, 8'h03, 1'b1);
        // exactly full, all periods equal, repeated arrivals
        for (i = 0; i < MAX_TASKS; i++)
            send_beat(16'd5, 16'((i * 3) % 4 * 1000), 8'(8'h10 + i), i == MAX_TASKS - 1);
        // overflow: the closing beat itself is dropped
        for (i = 0; i < MAX_TASKS + 2; i++)
            send_beat(16'(i % 3 + 1), 16'(9 - i), 8'(8'hA0 + i), i == MAX_TASKS + 1);

        while (beats_sent < BEAT_TARGET)
            send_random_set();
        task_valid <= 1'b0;

        while (results_due != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
